// File: hdl/nwbm_pkg.sv
`timescale 1ns / 1ps

package nwbm_pkg;

    localparam int ADDR_W    = 64;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int LANES     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_MASK_LOW       = 3'd2,
        REG_MASK_HIGH      = 3'd3,
        REG_PATTERN_LENGTH = 3'd4
    } cfg_reg_t;

    localparam logic [7:0] MASK_WILD     = 8'h00;
    localparam logic [7:0] MASK_HIGH_NIB = 8'hF0;
    localparam logic [7:0] MASK_LOW_NIB  = 8'h0F;
    localparam logic [7:0] MASK_FULL     = 8'hFF;

    typedef struct packed {
        logic [LANES*8-1:0] pattern;
        logic [LANES*8-1:0] mask;
        logic [LEN_W-1:0]   length;
    } cfg_t;

    // item held in the window stage
    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  seen;
        logic [ADDR_W-1:0] addr;
    } stage_t;

    function automatic logic position_ok(input logic [7:0] cur, input logic [7:0] pat,
                                         input logic [7:0] m);
        logic ok;
        if (m == MASK_WILD) begin
            ok = 1'b1;
        end else if (m == MASK_HIGH_NIB) begin
            ok = ((cur & MASK_HIGH_NIB) == pat);
        end else if (m == MASK_LOW_NIB) begin
            ok = ((cur & MASK_LOW_NIB) == pat);
        end else begin
            ok = ((cur & MASK_FULL) == pat);
        end
        return ok;
    endfunction

endpackage

// File: hdl/nwbm_regs.sv
`timescale 1ns / 1ps

module nwbm_regs
    import nwbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    logic [CFG_W-1:0] pat_lo_reg, pat_hi_reg, mask_lo_reg, mask_hi_reg;
    logic [LEN_W-1:0] len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_lo_reg  <= '0;
            pat_hi_reg  <= '0;
            mask_lo_reg <= '0;
            mask_hi_reg <= '0;
            len_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    pat_lo_reg  <= cfg_data;
                REG_PATTERN_HIGH:   pat_hi_reg  <= cfg_data;
                REG_MASK_LOW:       mask_lo_reg <= cfg_data;
                REG_MASK_HIGH:      mask_hi_reg <= cfg_data;
                REG_PATTERN_LENGTH: len_reg     <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.pattern = {pat_hi_reg, pat_lo_reg};
    assign cfg.mask    = {mask_hi_reg, mask_lo_reg};
    assign cfg.length  = len_reg;

endmodule

// File: hdl/nwbm_window.sv
`timescale 1ns / 1ps

module nwbm_window
    import nwbm_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [7:0]                   s_data_byte,
    input  logic                         s_restart,
    input  logic [ADDR_W-1:0]            s_base_address,
    input  logic                         take,
    output stage_t                       stage,
    output logic [PATTERN_MAX-1:0][7:0]  window
);

    logic [PATTERN_MAX-1:0][7:0] win_reg, win_next;
    logic                        valid_reg, valid_next;
    logic [LEN_W-1:0]            seen_reg, seen_next, seen_base;
    logic [ADDR_W-1:0]           next_addr_reg, next_addr_next, addr_base;
    logic [ADDR_W-1:0]           item_addr_reg, item_addr_next;
    logic                        accept;

    assign s_ready = !valid_reg || take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // a restart drops the count and rebases the address before the byte lands
        seen_base = s_restart ? '0 : seen_reg;
        addr_base = s_restart ? s_base_address : next_addr_reg;

        win_next       = win_reg;
        seen_next      = seen_reg;
        next_addr_next = next_addr_reg;
        item_addr_next = item_addr_reg;
        valid_next     = valid_reg && !take;
        if (accept) begin
            win_next[0] = s_data_byte;
            for (int i = 1; i < PATTERN_MAX; i++) begin
                win_next[i] = win_reg[i-1];
            end
            seen_next      = (seen_base == LEN_W'(PATTERN_MAX)) ? seen_base
                                                                : seen_base + 1'b1;
            item_addr_next = addr_base;
            next_addr_next = addr_base + 1'b1;
            valid_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            seen_reg      <= '0;
            next_addr_reg <= '0;
        end else begin
            valid_reg     <= valid_next;
            seen_reg      <= seen_next;
            next_addr_reg <= next_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg       <= win_next;
        item_addr_reg <= item_addr_next;
    end

    assign stage.valid = valid_reg;
    assign stage.seen  = seen_reg;
    assign stage.addr  = item_addr_reg;
    assign window      = win_reg;

endmodule

// File: hdl/nwbm_compare.sv
`timescale 1ns / 1ps

module nwbm_compare
    import nwbm_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfg_t                         cfg,
    input  stage_t                       stage,
    input  logic [PATTERN_MAX-1:0][7:0]  window,
    output logic                         take,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ADDR_W-1:0]            m_match_address
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic              len_ok, all_ok, hit;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    always_comb begin
        logic [LEN_W-1:0] sel;
        logic [7:0]       cur;
        len_ok = (cfg.length != '0) && (cfg.length <= LEN_W'(PATTERN_MAX))
                 && (stage.seen >= cfg.length);
        all_ok = 1'b1;
        sel    = '0;
        cur    = '0;
        // pattern position i lines up with the byte that arrived length-1-i ago
        for (int i = 0; i < PATTERN_MAX; i++) begin
            sel = cfg.length - LEN_W'(i) - 1'b1;
            if (LEN_W'(i) < cfg.length) begin
                cur = window[sel[IDX_W-1:0]];
                if (!position_ok(cur, cfg.pattern[8*i +: 8], cfg.mask[8*i +: 8])) begin
                    all_ok = 1'b0;
                end
            end
        end
        hit = stage.valid && len_ok && all_ok;
    end

    // drop a miss at once; hold a hit until the result register frees up
    assign take = stage.valid && (!hit || !out_valid_reg || m_ready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        if (hit && take) begin
            out_valid_next = 1'b1;
            out_addr_next  = stage.addr - ADDR_W'(cfg.length) + 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_addr_reg <= out_addr_next;
    end

    assign m_valid         = out_valid_reg;
    assign m_match_address = out_addr_reg;

endmodule

// File: hdl/nibble_wildcard_byte_matcher.sv
`timescale 1ns / 1ps
// Channel   Ports                                               Direction
// input     s_valid s_ready s_data_byte s_restart s_base_address  in
// result    m_valid m_ready m_match_address                       out
// config    cfg_valid cfg_ready cfg_index cfg_data                 in
//
// One byte per cycle while no matching byte waits behind a held result; a match shows on
// m_valid once its byte is taken into the window register and then, after the parallel
// compare, into the result register.
// A miss leaves the window stage the next cycle even while a result waits.
// Synchronous active-low reset clears the window count, address and both valids.
// A pending result stalls input only when the held byte also matches.
module nibble_wildcard_byte_matcher
    import nwbm_pkg::*;
#(
    parameter int PATTERN_MAX = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_restart,
    input  logic [ADDR_W-1:0]    s_base_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_match_address,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t                        cfg;
    stage_t                      stage;
    logic [PATTERN_MAX-1:0][7:0] window;
    logic                        take;

    nwbm_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nwbm_window #(.PATTERN_MAX(PATTERN_MAX)) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_restart      (s_restart),
        .s_base_address (s_base_address),
        .take           (take),
        .stage          (stage),
        .window         (window)
    );

    nwbm_compare #(.PATTERN_MAX(PATTERN_MAX)) u_compare (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .stage           (stage),
        .window          (window),
        .take            (take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match_address (m_match_address)
    );

endmodule

// File: hdl/nwbm_checker.sv
`timescale 1ns / 1ps

module nwbm_checker
    import nwbm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [ADDR_W-1:0] m_match_address
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an empty result register never blocks a request
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // a fresh result comes from an earlier accepted request
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching request");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_address))
        else $error("stalled result changed");

endmodule

bind nibble_wildcard_byte_matcher nwbm_checker u_nwbm_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_match_address (m_match_address)
);
